FILE: src/rbqt_pkg.sv
`timescale 1ns / 1ps
package rbqt_pkg;
  localparam int MaxReplicasDef    = 16;
  localparam int SlotsPerOriginDef = 64;
  localparam int DigestW = 256;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ECHO  = 2'd1,
    CMD_READY = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_VIEW    = 3'd1,
    ST_DIGEST  = 3'd2,
    ST_DUP     = 3'd3,
    ST_NOSLOT  = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_INIT  = 2'd0,
    PH_ECHO  = 2'd1,
    PH_READY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    REG_NUM_SERVERS = 2'd0,
    REG_FAULT_BOUND = 2'd1,
    REG_RECOVERY    = 2'd2,
    REG_VIEW        = 2'd3
  } reg_t;

  typedef enum logic [2:0] {
    BS_IDLE  = 3'd0,
    BS_READ  = 3'd1,
    BS_EXEC  = 3'd2,
    BS_OUT   = 3'd3,
    BS_SWEEP = 3'd4
  } bstate_t;

  typedef struct packed {
    logic [2:0] fault_bound;
    logic [2:0] recovery_extra;
  } quorum_cfg_t;
endpackage

FILE: src/rbqt_front.sv
`timescale 1ns / 1ps
// checks view and ids, computes the slot index, queues the item
module rbqt_front import rbqt_pkg::*; #(
  parameter int MAX_REPLICAS = MaxReplicasDef,
  parameter int SLOTS_PER_ORIGIN = SlotsPerOriginDef,
  parameter int IW = $clog2(MAX_REPLICAS),
  parameter int SW = $clog2(SLOTS_PER_ORIGIN),
  parameter int QW = 2 + 3 + IW + SW + 32 + IW + DigestW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    cmd,
  input  logic [31:0]   msg_view,
  input  logic [4:0]    origin_id,
  input  logic [31:0]   seq_number,
  input  logic [4:0]    sender_id,
  input  logic [DigestW-1:0] digest,
  input  logic [4:0]    replica_count,
  input  logic [31:0]   current_view,
  output logic          q_valid,
  input  logic          q_ready,
  output logic [QW-1:0] q_data
);
  localparam int Depth = 2;
  logic [QW-1:0] fifo [Depth];
  logic [1:0] count;
  logic wptr, rptr;
  logic [2:0] pre;
  logic org_ok, snd_ok;
  logic [IW-1:0] org_i, snd_i;
  logic [QW-1:0] entry;

  always_comb begin
    org_ok = origin_id != 5'd0 && origin_id <= replica_count
             && 32'(origin_id) <= 32'(MAX_REPLICAS);
    snd_ok = sender_id != 5'd0 && sender_id <= replica_count
             && 32'(sender_id) <= 32'(MAX_REPLICAS);
    org_i = IW'(origin_id - 5'd1);
    snd_i = IW'(sender_id - 5'd1);
    if (cmd == CMD_CLEAR) pre = ST_CLEARED;
    else if (msg_view != current_view) pre = ST_VIEW;
    else if (!org_ok || (cmd != CMD_INIT && !snd_ok)) pre = ST_NOSLOT;
    else pre = ST_OK;
    entry = {cmd, pre, org_i, seq_number[SW-1:0], seq_number, snd_i, digest};
  end

  assign in_ready = count != 2'(Depth);
  assign q_valid  = count != 2'd0;
  assign q_data   = fifo[rptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) fifo[wptr] <= entry;
    if (rst) begin
      count <= '0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (in_valid && in_ready) wptr <= ~wptr;
      if (q_valid && q_ready) rptr <= ~rptr;
      count <= count + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end
endmodule

FILE: src/rbqt_back.sv
`timescale 1ns / 1ps
// slot table read-modify-write; clear and reset sweep the table one slot per cycle
module rbqt_back import rbqt_pkg::*; #(
  parameter int MAX_REPLICAS = MaxReplicasDef,
  parameter int SLOTS_PER_ORIGIN = SlotsPerOriginDef,
  parameter int IW = $clog2(MAX_REPLICAS),
  parameter int SW = $clog2(SLOTS_PER_ORIGIN),
  parameter int QW = 2 + 3 + IW + SW + 32 + IW + DigestW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [QW-1:0] q_data,
  input  quorum_cfg_t   qcfg,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [5:0]    out_data
);
  localparam int NSlots = MAX_REPLICAS * SLOTS_PER_ORIGIN;
  localparam int AW = IW + SW;
  localparam int CW = $clog2(MAX_REPLICAS + 1);
  localparam int EW = 1 + 32 + 2 + DigestW + 2 * MAX_REPLICAS + 2 * CW;

  logic [EW-1:0] mem [NSlots];
  logic [EW-1:0] rd;
  bstate_t state, state_next;
  logic [AW-1:0] sweep_index;
  logic sweep_last;
  logic clr_due;

  logic [1:0] cmd;
  logic [2:0] pre;
  logic [AW-1:0] addr;
  logic [31:0] seq;
  logic [IW-1:0] snd;
  logic [DigestW-1:0] dig;
  logic hit_valid;

  logic [31:0] r_tag;
  logic [1:0] r_ph;
  logic [DigestW-1:0] r_dig;
  logic [MAX_REPLICAS-1:0] r_em, r_rm, bit_m;
  logic [CW-1:0] r_ec, r_rc;
  logic [1:0] n_ph;
  logic [MAX_REPLICAS-1:0] n_em, n_rm;
  logic [CW-1:0] n_ec, n_rc;
  logic [2:0] st;
  logic se, sr, dl, wr, alloc;
  logic [5:0] res;
  logic [4:0] quorum, relay_lvl;

  assign {cmd, pre, addr, seq, snd, dig} = q_data;
  assign {hit_valid, r_tag, r_ph, r_dig, r_em, r_rm, r_ec, r_rc} = rd;
  assign quorum = {1'b0, qcfg.fault_bound, 1'b0} + 5'(qcfg.recovery_extra) + 5'd1;
  assign relay_lvl = 5'(qcfg.fault_bound) + 5'd1;
  assign out_valid = state == BS_OUT;
  assign sweep_last = sweep_index == AW'(NSlots - 1);

  always_comb begin
    state_next = state;
    q_ready = 1'b0;
    unique case (state)
      BS_IDLE: if (q_valid) state_next = BS_READ;
      BS_READ: state_next = BS_EXEC;
      BS_EXEC: begin
        q_ready = 1'b1;
        state_next = BS_OUT;
      end
      BS_OUT: if (out_ready) state_next = clr_due ? BS_SWEEP : BS_IDLE;
      BS_SWEEP: if (sweep_last) state_next = BS_IDLE;
      default: state_next = BS_IDLE;
    endcase
  end

  always_comb begin
    bit_m = '0;
    bit_m[snd] = 1'b1;
    alloc = !hit_valid;
    n_ph = alloc ? PH_INIT : r_ph;
    n_em = alloc ? '0 : r_em;
    n_rm = alloc ? '0 : r_rm;
    n_ec = alloc ? '0 : r_ec;
    n_rc = alloc ? '0 : r_rc;
    st = ST_OK; se = 1'b0; sr = 1'b0; dl = 1'b0; wr = 1'b0;
    if (pre != ST_OK) st = pre;
    else if (!alloc && r_tag != seq) st = ST_NOSLOT;
    else if (!alloc && r_dig != dig) st = ST_DIGEST;
    else begin
      wr = 1'b1;
      case (cmd)
        CMD_INIT: if (n_ph == PH_INIT) begin
          n_ph = PH_ECHO; se = 1'b1;
        end
        CMD_ECHO: if ((n_em & bit_m) != '0) begin
          st = ST_DUP; wr = alloc;
        end else begin
          n_em = n_em | bit_m;
          n_ec = n_ec + CW'(1);
          if (5'(n_ec) == quorum && n_ph != PH_READY) begin
            se = n_ph == PH_INIT; sr = 1'b1; n_ph = PH_READY;
          end
        end
        default: if ((n_rm & bit_m) != '0) begin
          st = ST_DUP; wr = alloc;
        end else begin
          n_rm = n_rm | bit_m;
          n_rc = n_rc + CW'(1);
          if (5'(n_rc) == relay_lvl && n_ph != PH_READY) begin
            se = n_ph == PH_INIT; sr = 1'b1; n_ph = PH_READY;
          end
          dl = 5'(n_rc) == quorum;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == BS_IDLE) rd <= mem[addr];
    if (state == BS_SWEEP) mem[sweep_index] <= '0;
    else if (state == BS_EXEC && wr) mem[addr] <= {1'b1, seq, n_ph, dig, n_em, n_rm, n_ec, n_rc};
    if (state == BS_EXEC) res <= {st, dl, sr, se};
  end

  // reset starts with a full sweep; clear sweeps after its result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_SWEEP;
      sweep_index <= '0;
      clr_due <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BS_EXEC && pre == ST_CLEARED) clr_due <= 1'b1;
      else if (state == BS_SWEEP) clr_due <= 1'b0;
      if (state == BS_SWEEP) sweep_index <= sweep_last ? '0 : sweep_index + AW'(1);
    end
  end

  assign out_data = {res[5:3], res[5:3] == ST_OK ? res[2:0] : 3'b000};
endmodule

FILE: src/reliable_broadcast_quorum_tracker.sv
`timescale 1ns / 1ps
// an input beat passes the two-entry queue, then the slot read, read wait, update and result stages
// the back end starts the next queued item only after the result beat of the last one is taken
// clear sweeps the slot table one slot per cycle after its result beat (1024 slots by default)
// rst (synchronous) loads registers with 4, 1, 0, 1, empties the queue and sweeps all slots
module reliable_broadcast_quorum_tracker import rbqt_pkg::*; #(
  parameter int MAX_REPLICAS = MaxReplicasDef,
  parameter int SLOTS_PER_ORIGIN = SlotsPerOriginDef
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // cmd, msg_view, origin_id, seq_number, sender_id, digest_w0..w3, zero fill
  input  logic [335:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // send_echo, send_ready, deliver, status, zero fill
  output logic [7:0]   m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  localparam int IW = $clog2(MAX_REPLICAS);
  localparam int SW = $clog2(SLOTS_PER_ORIGIN);
  localparam int QW = 2 + 3 + IW + SW + 32 + IW + DigestW;

  logic [4:0] replica_count;
  logic [2:0] fault_bound, recovery_extra;
  logic [31:0] current_view;
  logic q_valid, q_ready;
  logic [QW-1:0] q_data;
  logic [5:0] res;
  quorum_cfg_t qcfg;
  reg_t ra;

  assign pready = 1'b1;
  assign ra = reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      replica_count <= 5'd4;
      fault_bound <= 3'd1;
      recovery_extra <= 3'd0;
      current_view <= 32'd1;
    end else if (psel && penable && pwrite) begin
      unique case (ra)
        REG_NUM_SERVERS: replica_count <= pwdata[4:0];
        REG_FAULT_BOUND: fault_bound <= pwdata[2:0];
        REG_RECOVERY:    recovery_extra <= pwdata[2:0];
        REG_VIEW:        current_view <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (ra)
      REG_NUM_SERVERS: prdata = 32'(replica_count);
      REG_FAULT_BOUND: prdata = 32'(fault_bound);
      REG_RECOVERY:    prdata = 32'(recovery_extra);
      REG_VIEW:        prdata = current_view;
      default:         prdata = '0;
    endcase
  end

  assign qcfg.fault_bound = fault_bound;
  assign qcfg.recovery_extra = recovery_extra;

  rbqt_front #(.MAX_REPLICAS(MAX_REPLICAS), .SLOTS_PER_ORIGIN(SLOTS_PER_ORIGIN)) u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .cmd(s_tdata[1:0]), .msg_view(s_tdata[33:2]), .origin_id(s_tdata[38:34]),
    .seq_number(s_tdata[70:39]), .sender_id(s_tdata[75:71]), .digest(s_tdata[331:76]),
    .replica_count, .current_view,
    .q_valid, .q_ready, .q_data
  );

  rbqt_back #(.MAX_REPLICAS(MAX_REPLICAS), .SLOTS_PER_ORIGIN(SLOTS_PER_ORIGIN)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data, .qcfg,
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(res)
  );

  assign m_tdata = {2'b00, res};
endmodule

FILE: tb/reliable_broadcast_quorum_tracker_tb.sv
`timescale 1ns / 1ps
module reliable_broadcast_quorum_tracker_tb;
  import rbqt_pkg::*;

  localparam int NumSlots = MaxReplicasDef * SlotsPerOriginDef;
  localparam int CycleLimit = 4000000;

  typedef struct packed {
    logic [255:0] digest;
    logic [4:0]   sender;
    logic [31:0]  seq;
    logic [4:0]   origin;
    logic [31:0]  view;
    cmd_t         cmd;
  } msg_t;

  typedef struct packed {
    status_t status;
    logic    deliver;
    logic    send_ready;
    logic    send_echo;
  } verdict_t;

  typedef struct {
    msg_t     msg;
    logic     typed;
    verdict_t want;
  } row_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [335:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [7:0]   m_tdata;
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  reliable_broadcast_quorum_tracker dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // predictor state
  logic [4:0]   cfg_servers;
  logic [2:0]   cfg_f, cfg_k;
  logic [31:0]  cfg_view;
  logic         sl_valid [NumSlots];
  logic [31:0]  sl_tag [NumSlots];
  phase_t       sl_phase [NumSlots];
  logic [255:0] sl_digest [NumSlots];
  logic [15:0]  sl_echo_map [NumSlots];
  logic [15:0]  sl_ready_map [NumSlots];
  int           sl_echo_cnt [NumSlots];
  int           sl_ready_cnt [NumSlots];

  verdict_t pending_verdicts[$];
  int errors = 0, sent = 0, got = 0, delivers = 0;
  int s_idle_pct = 0, m_idle_pct = 0;
  longint cycles = 0;

  function automatic logic id_good(logic [4:0] id);
    return id >= 1 && id <= cfg_servers && id <= MaxReplicasDef;
  endfunction

  function automatic void push_ready_phase(int s, ref verdict_t v);
    if (sl_phase[s] == PH_INIT) begin
      v.send_echo = 1;
      v.send_ready = 1;
      sl_phase[s] = PH_READY;
    end else if (sl_phase[s] == PH_ECHO) begin
      v.send_ready = 1;
      sl_phase[s] = PH_READY;
    end
  endfunction

  function automatic verdict_t track_quorum(msg_t m);
    verdict_t v;
    int s, quorum, relay_need;
    logic [15:0] bitv;
    v = '{status: ST_OK, default: 0};
    quorum = 2 * cfg_f + cfg_k + 1;
    relay_need = cfg_f + 1;
    if (m.cmd == CMD_CLEAR) begin
      foreach (sl_valid[i]) sl_valid[i] = 0;
      v.status = ST_CLEARED;
      return v;
    end
    if (m.view != cfg_view) begin
      v.status = ST_VIEW;
      return v;
    end
    if (!id_good(m.origin) || (m.cmd != CMD_INIT && !id_good(m.sender))) begin
      v.status = ST_NOSLOT;
      return v;
    end
    s = (m.origin - 1) * SlotsPerOriginDef + m.seq[5:0];
    if (sl_valid[s]) begin
      if (sl_tag[s] != m.seq) begin
        v.status = ST_NOSLOT;
        return v;
      end
      if (sl_digest[s] != m.digest) begin
        v.status = ST_DIGEST;
        return v;
      end
    end else begin
      sl_valid[s] = 1;
      sl_tag[s] = m.seq;
      sl_phase[s] = PH_INIT;
      sl_digest[s] = m.digest;
      sl_echo_map[s] = 0;
      sl_ready_map[s] = 0;
      sl_echo_cnt[s] = 0;
      sl_ready_cnt[s] = 0;
    end
    if (m.cmd == CMD_INIT) begin
      if (sl_phase[s] == PH_INIT) begin
        sl_phase[s] = PH_ECHO;
        v.send_echo = 1;
      end
      return v;
    end
    bitv = 16'd1 << (m.sender - 1);
    if (m.cmd == CMD_ECHO) begin
      if (sl_echo_map[s] & bitv) begin
        v.status = ST_DUP;
        return v;
      end
      sl_echo_map[s] |= bitv;
      sl_echo_cnt[s]++;
      if (sl_echo_cnt[s] == quorum) push_ready_phase(s, v);
      return v;
    end
    if (sl_ready_map[s] & bitv) begin
      v.status = ST_DUP;
      return v;
    end
    sl_ready_map[s] |= bitv;
    sl_ready_cnt[s]++;
    if (sl_ready_cnt[s] == relay_need) push_ready_phase(s, v);
    if (sl_ready_cnt[s] == quorum) v.deliver = 1;
    return v;
  endfunction

  task automatic apb_write(reg_t idx, logic [31:0] val);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
    case (idx)
      REG_NUM_SERVERS: cfg_servers = val[4:0];
      REG_FAULT_BOUND: cfg_f = val[2:0];
      REG_RECOVERY:    cfg_k = val[2:0];
      default:         cfg_view = val;
    endcase
  endtask

  // one beat into the block; typed rows check the predictor too
  task automatic send_msg(msg_t m, logic typed = 0, verdict_t want = '0);
    verdict_t v;
    while (s_idle_pct > 0 && $urandom_range(99) < s_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {4'd0, m.digest, m.sender, m.seq, m.origin, m.view, m.cmd};
    do @(posedge clk); while (!s_tready);
    v = track_quorum(m);
    if (typed && v != want) begin
      $error("typed row disagrees with predictor: %h vs %h", want, v);
      errors++;
    end
    pending_verdicts.push_back(v);
    sent++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      cycles++;
      if (cycles > CycleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
      m_tready <= !(m_idle_pct > 0 && $urandom_range(99) < m_idle_pct);
    end
  end

  always @(posedge clk) begin
    verdict_t act, exp_v;
    if (!rst && m_tvalid && m_tready) begin
      act = m_tdata[5:0];
      got++;
      if (pending_verdicts.size() == 0) begin
        $error("result beat with nothing expected: %h", m_tdata);
        errors++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (act.send_echo != exp_v.send_echo) begin
          $error("send_echo exp %0d got %0d", exp_v.send_echo, act.send_echo);
          errors++;
        end
        if (act.send_ready != exp_v.send_ready) begin
          $error("send_ready exp %0d got %0d", exp_v.send_ready, act.send_ready);
          errors++;
        end
        if (act.deliver != exp_v.deliver) begin
          $error("deliver exp %0d got %0d", exp_v.deliver, act.deliver);
          errors++;
        end
        if (act.status != exp_v.status) begin
          $error("status exp %0d got %0d", exp_v.status, act.status);
          errors++;
        end
        if (act.deliver) delivers++;
      end
    end
  end

  function automatic msg_t mk(cmd_t c, logic [31:0] vw, logic [4:0] o, logic [31:0] sq,
                              logic [4:0] sd, logic [255:0] dg);
    msg_t m;
    m.cmd = c;
    m.view = vw;
    m.origin = o;
    m.seq = sq;
    m.sender = sd;
    m.digest = dg;
    return m;
  endfunction

  function automatic logic [255:0] rand_digest();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic drain();
    s_tvalid <= 0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // well-formed instance with random order and some noise
  task automatic run_instance();
    logic [4:0] o;
    logic [31:0] sq;
    logic [255:0] dg;
    int n, pick;
    o = 5'($urandom_range(cfg_servers < 16 ? cfg_servers : 16, 1));
    sq = $urandom_range(3) == 0 ? $urandom : $urandom_range(200);
    dg = $urandom_range(3) == 0 ? '1 : rand_digest();
    n = $urandom_range(2 * cfg_servers + 3, 2);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 10)
        send_msg(mk(CMD_INIT, cfg_view, o, sq, 5'($urandom), dg));
      else if (pick < 50)
        send_msg(mk(CMD_ECHO, cfg_view, o, sq, 5'($urandom_range(cfg_servers, 1)), dg));
      else if (pick < 90)
        send_msg(mk(CMD_READY, cfg_view, o, sq, 5'($urandom_range(cfg_servers, 1)), dg));
      else if (pick < 93)
        send_msg(mk(cmd_t'($urandom_range(2)), $urandom, o, sq, 1, dg));
      else if (pick < 96)
        send_msg(mk(cmd_t'($urandom_range(2)), cfg_view, o, sq,
                    $urandom_range(1) ? 5'd0 : 5'($urandom_range(31, 17)), dg));
      else if (pick < 98)
        send_msg(mk(cmd_t'($urandom_range(2)), cfg_view, o, sq, 1, rand_digest()));
      else
        send_msg(mk(cmd_t'($urandom_range(2)), cfg_view, o, sq + 64, 1, dg));
    end
  endtask

  initial begin
    row_t rows[$];
    logic [255:0] d0;
    int lim;
    foreach (sl_valid[i]) sl_valid[i] = 0;
    cfg_servers = 4;
    cfg_f = 1;
    cfg_k = 0;
    cfg_view = 1;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    d0 = {64'h0123456789abcdef, 64'hfedcba9876543210, 64'hffffffffffffffff, 64'h0};
    // directed: register defaults n=4 f=1 k=0 view=1
    rows.push_back('{mk(CMD_CLEAR, 0, 0, 0, 0, '0), 1, '{ST_CLEARED, 0, 0, 0}});
    rows.push_back('{mk(CMD_INIT, 0, 1, 0, 1, d0), 1, '{ST_VIEW, 0, 0, 0}});
    rows.push_back('{mk(CMD_INIT, 32'hffffffff, 1, 0, 1, d0), 1, '{ST_VIEW, 0, 0, 0}});
    rows.push_back('{mk(CMD_INIT, 1, 0, 0, 1, d0), 1, '{ST_NOSLOT, 0, 0, 0}});
    rows.push_back('{mk(CMD_INIT, 1, 5, 0, 1, d0), 1, '{ST_NOSLOT, 0, 0, 0}});
    rows.push_back('{mk(CMD_ECHO, 1, 1, 0, 0, d0), 1, '{ST_NOSLOT, 0, 0, 0}});
    rows.push_back('{mk(CMD_READY, 1, 1, 0, 31, d0), 1, '{ST_NOSLOT, 0, 0, 0}});
    rows.push_back('{mk(CMD_INIT, 1, 1, 0, 0, d0), 1, '{ST_OK, 0, 0, 1}});
    rows.push_back('{mk(CMD_INIT, 1, 1, 0, 3, d0), 1, '{ST_OK, 0, 0, 0}});
    rows.push_back('{mk(CMD_ECHO, 1, 1, 0, 1, ~d0), 1, '{ST_DIGEST, 0, 0, 0}});
    rows.push_back('{mk(CMD_ECHO, 1, 1, 64, 1, d0), 1, '{ST_NOSLOT, 0, 0, 0}});
    rows.push_back('{mk(CMD_ECHO, 1, 1, 0, 1, d0), 0, '0});
    rows.push_back('{mk(CMD_ECHO, 1, 1, 0, 1, d0), 1, '{ST_DUP, 0, 0, 0}});
    rows.push_back('{mk(CMD_ECHO, 1, 1, 0, 4, d0), 0, '0});
    rows.push_back('{mk(CMD_ECHO, 1, 1, 0, 2, d0), 0, '0});
    rows.push_back('{mk(CMD_READY, 1, 1, 0, 1, d0), 0, '0});
    rows.push_back('{mk(CMD_READY, 1, 1, 0, 2, d0), 0, '0});
    rows.push_back('{mk(CMD_READY, 1, 1, 0, 3, d0), 0, '0});
    rows.push_back('{mk(CMD_READY, 1, 4, 32'hffffffff, 4, '1), 0, '0});
    rows.push_back('{mk(CMD_READY, 1, 4, 32'hffffffff, 3, '1), 0, '0});
    rows.push_back('{mk(CMD_CLEAR, 32'hffffffff, 31, 32'hffffffff, 31, '1), 1,
                     '{ST_CLEARED, 0, 0, 0}});
    foreach (rows[i]) send_msg(rows[i].msg, rows[i].typed, rows[i].want);
    drain();

    // f+1 == 2f+k+1 corner with f=0, and extremes of the registers
    apb_write(REG_FAULT_BOUND, 0);
    apb_write(REG_RECOVERY, 0);
    apb_write(REG_NUM_SERVERS, 1);
    apb_write(REG_VIEW, 32'hffffffff);
    send_msg(mk(CMD_READY, 32'hffffffff, 1, 7, 1, d0));
    send_msg(mk(CMD_ECHO, 32'hffffffff, 1, 8, 1, d0));
    send_msg(mk(CMD_ECHO, 32'hffffffff, 2, 8, 1, d0));
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      s_idle_pct = ph == 0 ? 22 : ph == 1 ? 74 : 0;
      m_idle_pct = ph == 0 ? 74 : ph == 1 ? 22 : 0;
      for (int cfgn = 0; cfgn < 3; cfgn++) begin
        case (cfgn)
          0: begin
            apb_write(REG_NUM_SERVERS, 16);
            apb_write(REG_FAULT_BOUND, 5);
            apb_write(REG_RECOVERY, $urandom_range(5));
          end
          1: begin
            apb_write(REG_NUM_SERVERS, $urandom_range(16, 4));
            apb_write(REG_FAULT_BOUND, 1);
            apb_write(REG_RECOVERY, 0);
          end
          default: begin
            apb_write(REG_NUM_SERVERS, $urandom_range(31, 7));
            apb_write(REG_FAULT_BOUND, $urandom_range(2));
            apb_write(REG_RECOVERY, 5);
          end
        endcase
        apb_write(REG_VIEW, $urandom);
        lim = sent + 85;
        while (sent < lim) begin
          if ($urandom_range(19) == 0) send_msg(mk(CMD_CLEAR, $urandom, 5'($urandom),
                                                  $urandom, 5'($urandom), rand_digest()));
          else run_instance();
        end
        drain();
      end
    end

    $display("covered %0d beats in, %0d results, %0d deliveries", sent, got, delivers);
    $display("register sweeps: quorum sizes from 1 up to 16, views at both ends");
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
